// ----- design/tsps_pkg.sv -----
// Shared types, widths and constants of the three-step phase-shift pixel pipeline.
package tsps_pkg;

  localparam int SAMPLE_BITS = 8;

  // Front-end arithmetic widths
  localparam int DIFF_W = SAMPLE_BITS + 1;          // a - c
  localparam int EXC_W  = SAMPLE_BITS + 2;          // 2b - a - c
  localparam int SUM_W  = SAMPLE_BITS + 2;          // a + b + c
  localparam int DSQ_W  = 2 * SAMPLE_BITS;          // (a - c)^2
  localparam int ESQ_W  = 2 * SAMPLE_BITS + 2;      // (2b - a - c)^2
  localparam int Q_W    = 2 * SAMPLE_BITS + 3;      // 3 d^2 + e^2

  // Square root of 64 Q
  localparam int ROOT_W = SAMPLE_BITS + 5;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // CORDIC datapath
  localparam int XY_W         = SAMPLE_BITS + 22;
  localparam int ACC_W        = 34;
  localparam int ANGLE_W      = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int X_SHIFT      = 16;
  localparam int SQRT3_Q16    = 113512;
  localparam logic signed [ACC_W-1:0] ACC_PI = {{(ACC_W-ANGLE_W){1'b0}}, 32'h8000_0000};

  // Pipeline depth
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_STAGES  = FRONT_STAGES + CORDIC_STEPS;
  localparam int ROOT_PAD     = CORDIC_STEPS - ROOT_W - 2;

  // Result formats
  localparam int LEVEL_W      = 10;
  localparam int PHASE_W      = 16;
  localparam int LEVEL_MAX    = 1023;
  localparam int PHASE_MAX    = 32767;
  localparam int PHASE_MIN    = -32768;
  localparam int PHASE_QUART  = 16384;
  localparam int PHASE_ROUND  = 32768;
  localparam int RND_SHIFT    = 16;

  // Divide by 3 of (4 sum + 1), reciprocal multiply plus one correction
  localparam int AMB_V_W    = SUM_W + 2;
  localparam int AMB_K      = AMB_V_W + 2;
  localparam int AMB_M      = (2 ** AMB_K) / 3;
  localparam int AMB_PROD_W = AMB_V_W + AMB_K;

  // Divide by 6 of (root + 3)
  localparam int MOD_V_W    = ROOT_W + 1;
  localparam int MOD_K      = MOD_V_W + 3;
  localparam int MOD_M      = (2 ** MOD_K) / 6;
  localparam int MOD_PROD_W = MOD_V_W + MOD_K;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] first_sample;
    logic [SAMPLE_BITS-1:0] second_sample;
    logic [SAMPLE_BITS-1:0] third_sample;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]        ambient_level;
    logic [LEVEL_W-1:0]        modulation_level;
    logic signed [PHASE_W-1:0] wrapped_phase;
  } out_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } vec_t;

  // Sideband riding along the CORDIC pipe
  typedef struct packed {
    logic [LEVEL_W-1:0]        ambient;
    logic                      force_en;
    logic signed [PHASE_W-1:0] force_phase;
  } side_t;

  // atan(2^-i), 2^31 = pi
  function automatic logic [ANGLE_W-1:0] atan_step(input int unsigned idx);
    case (idx)
      0:       return 32'h2000_0000;
      1:       return 32'h12E4_051E;
      2:       return 32'h09FB_385B;
      3:       return 32'h0511_11D4;
      4:       return 32'h028B_0D43;
      5:       return 32'h0145_D7E1;
      6:       return 32'h00A2_F61E;
      7:       return 32'h0051_7C55;
      8:       return 32'h0028_BE53;
      9:       return 32'h0014_5F2F;
      10:      return 32'h000A_2F98;
      11:      return 32'h0005_17CC;
      12:      return 32'h0002_8BE6;
      13:      return 32'h0001_45F3;
      14:      return 32'h0000_A2FA;
      15:      return 32'h0000_517D;
      16:      return 32'h0000_28BE;
      17:      return 32'h0000_145F;
      18:      return 32'h0000_0A30;
      19:      return 32'h0000_0518;
      20:      return 32'h0000_028C;
      21:      return 32'h0000_0146;
      22:      return 32'h0000_00A3;
      23:      return 32'h0000_0051;
      24:      return 32'h0000_0029;
      25:      return 32'h0000_0014;
      26:      return 32'h0000_000A;
      27:      return 32'h0000_0005;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- design/three_step_phase_shift.sv -----
// Top level of the three-step phase-shift pixel evaluator.
//
// Takes the three 8-bit samples of one pixel and returns its ambient level
// (mean, two fraction bits), fringe modulation (two fraction bits) and wrapped
// phase (signed 16-bit, 32768 = pi, +pi saturates to 32767). The block is
// fully pipelined and stateless: one pixel per clock unless a finished result
// waits on out_stall. Three front stages form the differences,
// squares and the divide-by-3 of the mean, then 28 CORDIC stages (one
// micro-rotation each) produce the angle while a one-bit-per-stage square
// root plus a divide-by-6 stage produce the modulation alongside, delayed to
// the same depth; a final output register rounds and saturates the phase.
// Valid bits shift alongside the data and the whole pipe advances whenever
// the output register is empty or being taken. A one-item skid register on
// the input keeps in_stall registered, so an item is still taken in the
// cycle a finished result waits on out_stall; in_stall rises only after that.
module three_step_phase_shift (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tsps_pkg::out_item_t out_data
);

  logic                                en;
  logic                                src_valid;
  tsps_pkg::in_item_t                  src_item;
  logic [tsps_pkg::PIPE_STAGES-1:0]    vld_r;

  logic [tsps_pkg::Q_W-1:0]            q;
  tsps_pkg::vec_t                      vec;
  tsps_pkg::side_t                     side_front;
  tsps_pkg::side_t                     side_end;
  logic signed [tsps_pkg::ACC_W-1:0]   acc_end;
  logic [tsps_pkg::LEVEL_W-1:0]        mod_level;

  logic signed [tsps_pkg::ACC_W:0]                      acc_rnd;
  logic signed [tsps_pkg::ACC_W-tsps_pkg::RND_SHIFT:0]  phase_wide;
  logic signed [tsps_pkg::PHASE_W-1:0]                  phase_nxt;

  logic                out_valid_r;
  tsps_pkg::out_item_t out_data_r;
  tsps_pkg::out_item_t out_data_nxt;

  // Whole pipe moves unless a finished result sits stalled in the output.
  assign en = !out_valid_r || !out_stall;

  tsps_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .in_stall  (in_stall),
    .en        (en),
    .src_valid (src_valid),
    .src_item  (src_item)
  );

  tsps_front u_front (
    .clk    (clk),
    .en     (en),
    .item_i (src_item),
    .q_o    (q),
    .vec_o  (vec),
    .side_o (side_front)
  );

  tsps_root u_root (
    .clk     (clk),
    .en      (en),
    .q_i     (q),
    .level_o (mod_level)
  );

  tsps_cordic u_cordic (
    .clk    (clk),
    .en     (en),
    .vec_i  (vec),
    .side_i (side_front),
    .acc_o  (acc_end),
    .side_o (side_end)
  );

  // Valid bits, one per pipeline register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[tsps_pkg::PIPE_STAGES-2:0], src_valid};
    end
  end

  // Round the 2^31 = pi angle to 16 bits (floor of acc + half), then saturate.
  assign acc_rnd    = (tsps_pkg::ACC_W+1)'(acc_end) + (tsps_pkg::ACC_W+1)'(tsps_pkg::PHASE_ROUND);
  assign phase_wide = acc_rnd[tsps_pkg::ACC_W:tsps_pkg::RND_SHIFT];

  always_comb begin
    if (side_end.force_en) begin
      // axis cases and the flat pixel (all three samples equal) bypass the CORDIC result
      phase_nxt = side_end.force_phase;
    end else if (phase_wide > tsps_pkg::PHASE_MAX) begin
      phase_nxt = tsps_pkg::PHASE_W'(tsps_pkg::PHASE_MAX);
    end else if (phase_wide < tsps_pkg::PHASE_MIN) begin
      phase_nxt = tsps_pkg::PHASE_W'(tsps_pkg::PHASE_MIN);
    end else begin
      phase_nxt = tsps_pkg::PHASE_W'(phase_wide);
    end

    out_data_nxt.ambient_level    = side_end.ambient;
    out_data_nxt.modulation_level = mod_level;
    out_data_nxt.wrapped_phase    = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[tsps_pkg::PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/tsps_skid.sv -----
// Input skid register: takes one item while the pipeline is held.
module tsps_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tsps_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               en,
  output logic               src_valid,
  output tsps_pkg::in_item_t src_item
);

  logic               full_r;
  logic               full_nxt;
  tsps_pkg::in_item_t item_r;

  assign in_stall  = full_r;
  assign src_valid = full_r | in_valid;
  assign src_item  = full_r ? item_r : in_item;

  always_comb begin
    full_nxt = full_r;
    if (en) begin
      full_nxt = 1'b0;
    end else if (in_valid && !full_r) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && !full_r) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- design/tsps_front.sv -----
// Front stages: differences, squares, ambient level and CORDIC pre-rotation.
module tsps_front (
  input  logic                           clk,
  input  logic                           en,
  input  tsps_pkg::in_item_t             item_i,
  output logic [tsps_pkg::Q_W-1:0]       q_o,
  output tsps_pkg::vec_t                 vec_o,
  output tsps_pkg::side_t                side_o
);

  // stage 1
  logic signed [tsps_pkg::DIFF_W-1:0] d_r;
  logic signed [tsps_pkg::EXC_W-1:0]  e_r;
  logic [tsps_pkg::SUM_W-1:0]         sum_r;

  // stage 2
  logic signed [2*tsps_pkg::DIFF_W-1:0] dsq_full;
  logic signed [2*tsps_pkg::EXC_W-1:0]  esq_full;
  logic signed [tsps_pkg::XY_W-1:0]     y_full;
  logic [tsps_pkg::AMB_V_W-1:0]         ambv;
  logic [tsps_pkg::AMB_PROD_W-1:0]      amb_prod;
  logic [tsps_pkg::DSQ_W-1:0]           dsq_r;
  logic [tsps_pkg::ESQ_W-1:0]           esq_r;
  logic signed [tsps_pkg::XY_W-1:0]     x_r;
  logic signed [tsps_pkg::XY_W-1:0]     y_r;
  logic [tsps_pkg::AMB_V_W-1:0]         ambv_r;
  logic [tsps_pkg::AMB_V_W-1:0]         ambq_r;
  logic                                 dz_r;
  logic                                 dpos_r;
  logic                                 ez_r;
  logic                                 eneg_r;

  // stage 3
  logic [tsps_pkg::AMB_V_W-1:0] amb_rem;
  logic [tsps_pkg::AMB_V_W-1:0] amb_fix;
  logic [tsps_pkg::Q_W-1:0]     q_r;
  tsps_pkg::vec_t               vec_nxt;
  tsps_pkg::vec_t               vec_r;
  tsps_pkg::side_t              side_nxt;
  tsps_pkg::side_t              side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= tsps_pkg::DIFF_W'(item_i.first_sample) - tsps_pkg::DIFF_W'(item_i.third_sample);
      e_r   <= tsps_pkg::EXC_W'({item_i.second_sample, 1'b0})
             - tsps_pkg::EXC_W'(item_i.first_sample) - tsps_pkg::EXC_W'(item_i.third_sample);
      sum_r <= tsps_pkg::SUM_W'(item_i.first_sample) + tsps_pkg::SUM_W'(item_i.second_sample)
             + tsps_pkg::SUM_W'(item_i.third_sample);
    end
  end

  assign dsq_full = d_r * d_r;
  assign esq_full = e_r * e_r;
  assign y_full   = tsps_pkg::XY_W'(d_r) * tsps_pkg::XY_W'(tsps_pkg::SQRT3_Q16);
  assign ambv     = {sum_r, 2'b01};   // 4 sum + 1
  assign amb_prod = tsps_pkg::AMB_PROD_W'(ambv) * tsps_pkg::AMB_PROD_W'(tsps_pkg::AMB_M);

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r  <= dsq_full[tsps_pkg::DSQ_W-1:0];
      esq_r  <= esq_full[tsps_pkg::ESQ_W-1:0];
      y_r    <= y_full;
      x_r    <= tsps_pkg::XY_W'(e_r) <<< tsps_pkg::X_SHIFT;
      ambv_r <= ambv;
      ambq_r <= tsps_pkg::AMB_V_W'(amb_prod >> tsps_pkg::AMB_K);
      dz_r   <= (d_r == '0);
      dpos_r <= !d_r[tsps_pkg::DIFF_W-1] && (d_r != '0);
      ez_r   <= (e_r == '0);
      eneg_r <= e_r[tsps_pkg::EXC_W-1];
    end
  end

  // reciprocal estimate is low by at most one
  assign amb_rem = ambv_r - tsps_pkg::AMB_V_W'({ambq_r, 1'b0}) - ambq_r;
  assign amb_fix = (amb_rem >= tsps_pkg::AMB_V_W'(3)) ? ambq_r + 1'b1 : ambq_r;

  always_comb begin
    vec_nxt.x   = x_r;
    vec_nxt.y   = y_r;
    vec_nxt.acc = '0;
    if (eneg_r) begin
      // left half-plane: rotate by pi first
      vec_nxt.x   = -x_r;
      vec_nxt.y   = -y_r;
      vec_nxt.acc = dpos_r ? tsps_pkg::ACC_PI : -tsps_pkg::ACC_PI;
    end

    if (amb_fix > tsps_pkg::AMB_V_W'(tsps_pkg::LEVEL_MAX)) begin
      side_nxt.ambient = '1;
    end else begin
      side_nxt.ambient = tsps_pkg::LEVEL_W'(amb_fix);
    end

    side_nxt.force_en = dz_r | ez_r;
    if (dz_r) begin
      side_nxt.force_phase = eneg_r ? tsps_pkg::PHASE_W'(tsps_pkg::PHASE_MAX) : '0;
    end else begin
      side_nxt.force_phase = dpos_r ? tsps_pkg::PHASE_W'(tsps_pkg::PHASE_QUART)
                                    : tsps_pkg::PHASE_W'(-tsps_pkg::PHASE_QUART);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= tsps_pkg::Q_W'({dsq_r, 1'b0}) + tsps_pkg::Q_W'(dsq_r) + tsps_pkg::Q_W'(esq_r);
      vec_r  <= vec_nxt;
      side_r <= side_nxt;
    end
  end

  assign q_o    = q_r;
  assign vec_o  = vec_r;
  assign side_o = side_r;

endmodule

// ----- design/tsps_root.sv -----
// Modulation level: pipelined square root of 64 Q, divide by 6, delay match.
module tsps_root (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tsps_pkg::Q_W-1:0]       q_i,
  output logic [tsps_pkg::LEVEL_W-1:0]   level_o
);

  logic [tsps_pkg::RAD_W-1:0]  rad_r  [tsps_pkg::ROOT_W];
  logic [tsps_pkg::REM_W-1:0]  rem_r  [tsps_pkg::ROOT_W];
  logic [tsps_pkg::ROOT_W-1:0] root_r [tsps_pkg::ROOT_W];

  logic [tsps_pkg::MOD_V_W-1:0]    div_v;
  logic [tsps_pkg::MOD_PROD_W-1:0] div_prod;
  logic [tsps_pkg::MOD_V_W-1:0]    divv_r;
  logic [tsps_pkg::MOD_V_W-1:0]    divq_r;
  logic [tsps_pkg::MOD_V_W-1:0]    div_rem;
  logic [tsps_pkg::MOD_V_W-1:0]    div_fix;
  logic [tsps_pkg::LEVEL_W-1:0]    level_nxt;
  logic [tsps_pkg::LEVEL_W-1:0]    level_r;

  // one root bit per stage, restoring
  for (genvar i = 0; i < tsps_pkg::ROOT_W; i++) begin : g_bit
    logic [tsps_pkg::RAD_W-1:0]  cur_rad;
    logic [tsps_pkg::REM_W-1:0]  cur_rem;
    logic [tsps_pkg::ROOT_W-1:0] cur_root;
    logic [tsps_pkg::REM_W+1:0]  trial;
    logic [tsps_pkg::REM_W+1:0]  sub;

    if (i == 0) begin : g_first
      assign cur_rad  = tsps_pkg::RAD_W'(q_i) << 6;
      assign cur_rem  = '0;
      assign cur_root = '0;
    end else begin : g_rest
      assign cur_rad  = rad_r[i-1];
      assign cur_rem  = rem_r[i-1];
      assign cur_root = root_r[i-1];
    end

    assign trial = {cur_rem, cur_rad[tsps_pkg::RAD_W-1 -: 2]};
    assign sub   = (tsps_pkg::REM_W+2)'({cur_root, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i] <= cur_rad << 2;
        if (trial >= sub) begin
          rem_r[i]  <= tsps_pkg::REM_W'(trial - sub);
          root_r[i] <= {cur_root[tsps_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[i]  <= tsps_pkg::REM_W'(trial);
          root_r[i] <= {cur_root[tsps_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // n = floor((root + 3) / 6)
  assign div_v    = tsps_pkg::MOD_V_W'(root_r[tsps_pkg::ROOT_W-1]) + tsps_pkg::MOD_V_W'(3);
  assign div_prod = tsps_pkg::MOD_PROD_W'(div_v) * tsps_pkg::MOD_PROD_W'(tsps_pkg::MOD_M);

  always_ff @(posedge clk) begin
    if (en) begin
      divv_r <= div_v;
      divq_r <= tsps_pkg::MOD_V_W'(div_prod >> tsps_pkg::MOD_K);
    end
  end

  assign div_rem = divv_r - tsps_pkg::MOD_V_W'({divq_r, 2'b00})
                 - tsps_pkg::MOD_V_W'({divq_r, 1'b0});
  assign div_fix = (div_rem >= tsps_pkg::MOD_V_W'(6)) ? divq_r + 1'b1 : divq_r;

  always_comb begin
    if (div_fix > tsps_pkg::MOD_V_W'(tsps_pkg::LEVEL_MAX)) begin
      level_nxt = '1;
    end else begin
      level_nxt = tsps_pkg::LEVEL_W'(div_fix);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= level_nxt;
    end
  end

  // pad out to the CORDIC latency
  if (tsps_pkg::ROOT_PAD > 0) begin : g_pad
    logic [tsps_pkg::LEVEL_W-1:0] pad_r [tsps_pkg::ROOT_PAD];
    for (genvar p = 0; p < tsps_pkg::ROOT_PAD; p++) begin : g_tap
      always_ff @(posedge clk) begin
        if (en) begin
          pad_r[p] <= (p == 0) ? level_r : pad_r[(p == 0) ? 0 : p-1];
        end
      end
    end
    assign level_o = pad_r[tsps_pkg::ROOT_PAD-1];
  end else begin : g_nopad
    assign level_o = level_r;
  end

endmodule

// ----- design/tsps_cordic.sv -----
// Pipelined CORDIC vectoring, one micro-rotation per stage.
module tsps_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  tsps_pkg::vec_t                      vec_i,
  input  tsps_pkg::side_t                     side_i,
  output logic signed [tsps_pkg::ACC_W-1:0]   acc_o,
  output tsps_pkg::side_t                     side_o
);

  tsps_pkg::vec_t  step_r [tsps_pkg::CORDIC_STEPS];
  tsps_pkg::side_t side_r [tsps_pkg::CORDIC_STEPS];

  for (genvar i = 0; i < tsps_pkg::CORDIC_STEPS; i++) begin : g_step
    tsps_pkg::vec_t                   cur;
    tsps_pkg::side_t                  cur_side;
    tsps_pkg::vec_t                   nxt;
    logic signed [tsps_pkg::XY_W-1:0] cx;
    logic signed [tsps_pkg::XY_W-1:0] cy;
    logic signed [tsps_pkg::XY_W-1:0] xs;
    logic signed [tsps_pkg::XY_W-1:0] ys;
    logic signed [tsps_pkg::ACC_W-1:0] ang;

    if (i == 0) begin : g_first
      assign cur      = vec_i;
      assign cur_side = side_i;
    end else begin : g_rest
      assign cur      = step_r[i-1];
      assign cur_side = side_r[i-1];
    end

    assign cx  = cur.x;
    assign cy  = cur.y;
    assign xs  = cx >>> i;
    assign ys  = cy >>> i;
    assign ang = tsps_pkg::ACC_W'(tsps_pkg::atan_step(i));

    always_comb begin
      if (!cy[tsps_pkg::XY_W-1]) begin
        nxt.x   = cx + ys;
        nxt.y   = cy - xs;
        nxt.acc = cur.acc + ang;
      end else begin
        nxt.x   = cx - ys;
        nxt.y   = cy + xs;
        nxt.acc = cur.acc - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        step_r[i] <= nxt;
        side_r[i] <= cur_side;
      end
    end
  end

  assign acc_o  = step_r[tsps_pkg::CORDIC_STEPS-1].acc;
  assign side_o = side_r[tsps_pkg::CORDIC_STEPS-1];

endmodule

// ----- design/tsps_check.sv -----
// Port-level checker for the phase-shift pipeline, bound to the top level.
module tsps_check (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tsps_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tsps_pkg::out_item_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // offered item stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // skid only fills while the output is blocked
  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall raised without output backpressure");

  // and only with an item offered
  a_skid_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall raised without an offered item");

  // skid drains as soon as the pipe moves
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !(out_valid && out_stall) |=> !in_stall)
    else $error("skid did not drain");

endmodule

bind three_step_phase_shift tsps_check u_tsps_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
